>>> design/msta_pkg.sv
// shared types and constants of the mesh segment triangle assembler
`default_nettype none
package msta_pkg;

  localparam logic [31:0] MAGIC_WORD = 32'h314C_4D53;

  typedef enum logic [2:0] {
    ST_TRI    = 3'd0,
    ST_MAGIC  = 3'd1,
    ST_TYPE   = 3'd2,
    ST_RANGE  = 3'd3,
    ST_OVFL   = 3'd4,
    ST_STRIP  = 3'd5
  } status_t;

  // one vertex row, x in the low word
  typedef logic [2:0][31:0] vtx_t;

  // per accepted beat: result job, vertex read and strip slot move
  typedef struct packed {
    logic    job_valid;
    status_t job_status;
    logic    job_quad;
    logic    rd_en;
    logic [1:0] rd_slot;
    logic    shuf_en;
    logic    shuf_dst;
  } ctl_t;

  typedef struct packed {
    status_t          status;
    logic [8:0][31:0] crd;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

>>> design/mesh_segment_triangle_assembler.sv
// top level of the mesh segment triangle assembler
`default_nettype none
// takes a mesh file one byte per beat and returns resolved triangles. the
// file opens with the magic word and a checksum that is skipped; then come
// segments of type byte, little-endian length and body. vertex lists (float,
// or double rounded to float32) reload the vertex store; triangle, quad and
// strip segments return triangles of nine float32 words. one byte is taken
// every cycle while in_ready is high: each index fetches its vertex row from
// the store as soon as its four bytes are in, so the triangle of a record
// is assembled in the cycle after its last byte and lands in a four-entry
// result queue. a quad record gives two results in that cycle. input ready
// drops only while the queue plus the results still being assembled would
// not leave room for two more, so a stalled output side holds the input once
// more than two results wait. an error returns one result with its status
// and zero coordinates, then every byte is dropped until a byte with
// start_of_file. store rows that were never written since power-up read as
// garbage, but only indices below the current vertex count are ever returned.
module mesh_segment_triangle_assembler #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_ax,
  output logic [31:0]      out_ay,
  output logic [31:0]      out_az,
  output logic [31:0]      out_bx,
  output logic [31:0]      out_by,
  output logic [31:0]      out_bz,
  output logic [31:0]      out_cx,
  output logic [31:0]      out_cy,
  output logic [31:0]      out_cz,
  output logic             out_last_of_run
);
  import msta_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);

  logic          accept;
  ctl_t          ctl;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  vtx_t          wr_data, rd_data;
  res_t          res;

  // input beat taken
  assign accept = in_valid && in_ready;

  msta_parser #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .sof       (in_start_of_file),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // rows are only written in vertex lists and only read in index segments
  msta_vstore #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_vstore (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (ctl.rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  msta_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rd_data   (rd_data),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  // result fields, first vertex in the low words
  assign out_status      = res.status;
  assign out_ax          = res.crd[0];
  assign out_ay          = res.crd[1];
  assign out_az          = res.crd[2];
  assign out_bx          = res.crd[3];
  assign out_by          = res.crd[4];
  assign out_bz          = res.crd[5];
  assign out_cx          = res.crd[6];
  assign out_cy          = res.crd[7];
  assign out_cz          = res.crd[8];
  assign out_last_of_run = res.last;

endmodule
`default_nettype wire

>>> design/msta_vstore.sv
// vertex store: one row of three float32 words per vertex
`default_nettype none
module msta_vstore #(
  parameter int VERTEX_DEPTH = 4096,
  localparam int AW = $clog2(VERTEX_DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire msta_pkg::vtx_t wr_data,
  input  wire logic           rd_en,
  input  wire logic [AW-1:0]  rd_addr,
  output msta_pkg::vtx_t      rd_data_r
);
  import msta_pkg::*;

  vtx_t mem [VERTEX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> design/msta_parser.sv
// byte parser: header, segments, record assembly and index checks
`default_nettype none
module msta_parser #(
  parameter int VERTEX_DEPTH = 4096,
  localparam int AW = $clog2(VERTEX_DEPTH),
  localparam int CW = $clog2(VERTEX_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          sof,
  output msta_pkg::ctl_t     ctl,
  output logic [AW-1:0]      rd_addr,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output msta_pkg::vtx_t     wr_data
);
  import msta_pkg::*;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_CRC, PH_TYPE, PH_LEN, PH_SKIP, PH_REC
  } phase_t;

  localparam logic [2:0] K_COMMENT = 3'd0;
  localparam logic [2:0] K_FLOAT   = 3'd1;
  localparam logic [2:0] K_DOUBLE  = 3'd2;
  localparam logic [2:0] K_TRI     = 3'd3;
  localparam logic [2:0] K_QUAD    = 3'd4;
  localparam logic [2:0] K_STRIP   = 3'd5;

  localparam logic [31:0] OVF_F = 32'(12 * (VERTEX_DEPTH + 1));
  localparam logic [31:0] OVF_D = 32'(24 * (VERTEX_DEPTH + 1));

  function automatic logic [31:0] dbl_to_f32(input logic [63:0] b);
    logic [31:0]        sgn;
    logic [10:0]        ex;
    logic [51:0]        man;
    logic signed [12:0] fe;
    logic signed [13:0] shf;
    logic [52:0]        full;
    logic [52:0]        sr;
    logic [52:0]        mask;
    logic [24:0]        r;
    logic               rnd;
    logic [5:0]         sh;
    logic [31:0]        res;
    sgn  = {b[63], 31'd0};
    ex   = b[62:52];
    man  = b[51:0];
    fe   = $signed({2'b00, ex}) - 13'sd896;
    shf  = 14'sd30 - $signed({fe[12], fe});
    full = {1'b1, man};
    sr   = '0;
    mask = '0;
    r    = '0;
    rnd  = 1'b0;
    sh   = '0;
    res  = sgn;
    if (ex == 11'h7FF) begin
      res = (man != '0) ? (sgn | 32'h7FC0_0000 | {9'd0, man[51:29]})
                        : (sgn | 32'h7F80_0000);
    end else if (ex == '0) begin
      res = sgn;
    end else if (fe >= 13'sd255) begin
      res = sgn | 32'h7F80_0000;
    end else if (fe >= 13'sd1) begin
      rnd = full[28] & ((|full[27:0]) | full[29]);
      r   = {1'b0, full[52:29]} + 25'(rnd);
      if (r[24]) begin
        fe  = fe + 13'sd1;
        res = (fe >= 13'sd255) ? (sgn | 32'h7F80_0000) : (sgn | {1'b0, fe[7:0], 23'd0});
      end else begin
        res = sgn | {1'b0, fe[7:0], r[22:0]};
      end
    end else if (shf >= 14'sd60) begin
      res = sgn;
    end else begin
      sh   = shf[5:0];
      sr   = full >> sh;
      mask = (53'd1 << (sh - 6'd1)) - 53'd1;
      rnd  = full[sh - 6'd1] & ((|(full & mask)) | sr[0]);
      r    = sr[24:0] + 25'(rnd);
      res  = sgn | {7'd0, r};
    end
    return res;
  endfunction

  phase_t         phase_r, phase_nxt, ph_e;
  logic [4:0]     cnt_r, cnt_nxt, cnt_e, cnt_inc;
  logic [2:0]     kind_r, kind_nxt, kind_e;
  logic [31:0]    left_r, left_nxt, left_e;
  logic [63:0]    acc_r, acc_nxt;
  logic [31:0]    fx_r [2];
  logic [31:0]    fx_nxt [2];
  logic [31:0]    idx_r [3];
  logic [31:0]    idx_nxt [3];
  logic [CW-1:0]  vcnt_r, vcnt_nxt, vcnt_e;
  logic           started_r, started_nxt, started_e;
  logic           par_r, par_nxt, par_e;
  logic           err_r, err_nxt, err_e;
  logic [31:0]    w32, conv, rem, n0, n1;
  logic [4:0]     rsize, nsize;
  logic           ok;

  function automatic logic ir(input logic [31:0] x, input logic [CW-1:0] c);
    return x < 32'(c);
  endfunction

  assign acc_nxt = {data_byte, acc_r[63:8]};
  assign w32     = acc_nxt[63:32];
  assign conv    = dbl_to_f32(acc_nxt);

  always_comb begin
    ph_e      = sof ? PH_MAGIC : phase_r;
    cnt_e     = sof ? '0 : cnt_r;
    kind_e    = sof ? K_COMMENT : kind_r;
    left_e    = sof ? '0 : left_r;
    vcnt_e    = sof ? '0 : vcnt_r;
    started_e = sof ? 1'b0 : started_r;
    par_e     = sof ? 1'b0 : par_r;
    err_e     = sof ? 1'b0 : err_r;
    cnt_inc   = cnt_e + 5'd1;

    case (kind_e)
      K_DOUBLE: rsize = 5'd24;
      K_QUAD:   rsize = 5'd16;
      K_STRIP:  rsize = started_e ? 5'd4 : 5'd12;
      default:  rsize = 5'd12;
    endcase
    nsize = (kind_e == K_STRIP) ? 5'd4 : rsize;
    rem   = left_e - 32'(rsize);
    n0    = par_e ? idx_r[0] : idx_r[2];
    n1    = par_e ? idx_r[2] : idx_r[1];
    ok    = 1'b0;

    phase_nxt   = ph_e;
    cnt_nxt     = cnt_e;
    kind_nxt    = kind_e;
    left_nxt    = left_e;
    vcnt_nxt    = vcnt_e;
    started_nxt = started_e;
    par_nxt     = par_e;
    err_nxt     = err_e;
    fx_nxt      = fx_r;
    idx_nxt     = idx_r;

    ctl     = '0;
    rd_addr = w32[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = vcnt_e[AW-1:0];
    wr_data = {(kind_e == K_DOUBLE) ? conv : w32, fx_r[1], fx_r[0]};

    if (accept && !err_e) begin
      unique case (ph_e)
        PH_MAGIC: begin
          cnt_nxt = cnt_inc;
          if (cnt_e == 5'd3) begin
            cnt_nxt = '0;
            if (w32 != MAGIC_WORD) begin
              err_nxt = 1'b1;
              ctl.job_valid  = 1'b1;
              ctl.job_status = ST_MAGIC;
            end else begin
              phase_nxt = PH_CRC;
            end
          end
        end
        PH_CRC: begin
          cnt_nxt = cnt_inc;
          if (cnt_e == 5'd3) begin
            cnt_nxt   = '0;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (data_byte > 8'd5) begin
            err_nxt = 1'b1;
            ctl.job_valid  = 1'b1;
            ctl.job_status = ST_TYPE;
          end else begin
            kind_nxt  = data_byte[2:0];
            cnt_nxt   = '0;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          cnt_nxt = cnt_inc;
          if (cnt_e == 5'd3) begin
            cnt_nxt  = '0;
            left_nxt = w32;
            case (kind_e)
              K_COMMENT: phase_nxt = (w32 != '0) ? PH_SKIP : PH_TYPE;
              K_FLOAT, K_DOUBLE: begin
                if (w32 >= ((kind_e == K_FLOAT) ? OVF_F : OVF_D)) begin
                  err_nxt = 1'b1;
                  ctl.job_valid  = 1'b1;
                  ctl.job_status = ST_OVFL;
                end else begin
                  vcnt_nxt  = '0;
                  phase_nxt = (w32 >= ((kind_e == K_FLOAT) ? 32'd12 : 32'd24)) ? PH_REC
                                                                               : PH_TYPE;
                end
              end
              K_TRI:  phase_nxt = (w32 >= 32'd12) ? PH_REC : PH_TYPE;
              K_QUAD: phase_nxt = (w32 >= 32'd16) ? PH_REC : PH_TYPE;
              default: begin
                if (w32 < 32'd12) begin
                  err_nxt = 1'b1;
                  ctl.job_valid  = 1'b1;
                  ctl.job_status = ST_STRIP;
                end else begin
                  started_nxt = 1'b0;
                  par_nxt     = 1'b0;
                  phase_nxt   = PH_REC;
                end
              end
            endcase
          end
        end
        PH_SKIP: begin
          left_nxt = left_e - 32'd1;
          if (left_e == 32'd1) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_REC: begin
          cnt_nxt = cnt_inc;
          // gather words as they complete
          if (kind_e == K_FLOAT && cnt_e[1:0] == 2'd3 && !cnt_e[3]) begin
            fx_nxt[cnt_e[2]] = w32;
          end
          if (kind_e == K_DOUBLE && cnt_e[2:0] == 3'd7 && !cnt_e[4]) begin
            fx_nxt[cnt_e[3]] = conv;
          end
          if ((kind_e == K_TRI || kind_e == K_QUAD || kind_e == K_STRIP)
              && cnt_e[1:0] == 2'd3) begin
            ctl.rd_en = 1'b1;
            if (kind_e == K_STRIP && started_e) begin
              ctl.shuf_en  = 1'b1;
              ctl.shuf_dst = par_e;
              ctl.rd_slot  = 2'd2;
              idx_nxt[0]   = n0;
              idx_nxt[1]   = n1;
              idx_nxt[2]   = w32;
            end else begin
              ctl.rd_slot = cnt_e[3:2];
              if (cnt_e[3:2] != 2'd3) begin
                idx_nxt[cnt_e[3:2]] = w32;
              end
            end
          end
          if (cnt_inc == rsize) begin
            cnt_nxt  = '0;
            left_nxt = rem;
            if (rem < 32'(nsize)) begin
              phase_nxt = PH_TYPE;
            end
            case (kind_e)
              K_FLOAT, K_DOUBLE: begin
                if (vcnt_e < CW'(VERTEX_DEPTH)) begin
                  wr_en    = 1'b1;
                  vcnt_nxt = vcnt_e + CW'(1);
                end
              end
              default: begin
                if (kind_e == K_TRI) begin
                  ok = ir(idx_r[0], vcnt_e) & ir(idx_r[1], vcnt_e) & ir(w32, vcnt_e);
                end else if (kind_e == K_QUAD) begin
                  ok = ir(idx_r[0], vcnt_e) & ir(idx_r[1], vcnt_e)
                     & ir(idx_r[2], vcnt_e) & ir(w32, vcnt_e);
                end else if (!started_e) begin
                  ok = ir(idx_r[0], vcnt_e) & ir(idx_r[1], vcnt_e) & ir(w32, vcnt_e);
                  started_nxt = 1'b1;
                  par_nxt     = 1'b1;
                end else begin
                  ok = ir(n0, vcnt_e) & ir(n1, vcnt_e) & ir(w32, vcnt_e);
                  par_nxt = ~par_e;
                end
                ctl.job_valid  = 1'b1;
                ctl.job_status = ok ? ST_TRI : ST_RANGE;
                ctl.job_quad   = (kind_e == K_QUAD);
                err_nxt        = ~ok;
              end
            endcase
          end
        end
        default: phase_nxt = PH_MAGIC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC;
      cnt_r     <= '0;
      kind_r    <= K_COMMENT;
      left_r    <= '0;
      vcnt_r    <= '0;
      started_r <= 1'b0;
      par_r     <= 1'b0;
      err_r     <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      kind_r    <= kind_nxt;
      left_r    <= left_nxt;
      vcnt_r    <= vcnt_nxt;
      started_r <= started_nxt;
      par_r     <= par_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= acc_nxt;
      fx_r  <= fx_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/msta_asm.sv
// vertex slots, triangle assembly and result queue
`default_nettype none
module msta_asm (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire msta_pkg::ctl_t ctl,
  input  wire msta_pkg::vtx_t rd_data,
  input  wire logic           out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output msta_pkg::res_t      res
);
  import msta_pkg::*;

  logic       job_valid_r, job_quad_r, rd_pend_r;
  status_t    job_status_r;
  logic [1:0] rd_slot_r;
  vtx_t       slot_r [4];
  vtx_t       s [4];
  res_t       r0, r1;
  res_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic [1:0] n_push;
  logic       pop;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s[k] = (rd_pend_r && rd_slot_r == 2'(k)) ? rd_data : slot_r[k];
    end
  end

  always_comb begin
    r0 = '0;
    r1 = '0;
    n_push = 2'd0;
    if (job_valid_r) begin
      r0.status = job_status_r;
      r0.last   = 1'b1;
      n_push    = 2'd1;
      if (job_status_r == ST_TRI) begin
        r0.crd  = {s[2], s[1], s[0]};
        r0.last = ~job_quad_r;
        if (job_quad_r) begin
          n_push    = 2'd2;
          r1.status = ST_TRI;
          r1.crd    = {s[3], s[2], s[0]};
          r1.last   = 1'b1;
        end
      end
    end
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign res       = q_r[rp_r];
  assign in_ready  = (cnt_r + {1'b0, n_push}) <= 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
    end else begin
      job_valid_r <= ctl.job_valid;
      rd_pend_r   <= ctl.rd_en;
      wp_r        <= wp_r + n_push;
      rp_r        <= rp_r + 2'(pop);
      cnt_r       <= cnt_r + {1'b0, n_push} - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    job_status_r <= ctl.job_status;
    job_quad_r   <= ctl.job_quad;
    rd_slot_r    <= ctl.rd_slot;
    if (ctl.shuf_en) begin
      slot_r[{1'b0, ctl.shuf_dst}] <= s[2];
    end
    if (rd_pend_r) begin
      slot_r[rd_slot_r] <= rd_data;
    end
    if (n_push != 2'd0) begin
      q_r[wp_r] <= r0;
    end
    if (n_push == 2'd2) begin
      q_r[wp_r + 2'd1] <= r1;
    end
  end

endmodule
`default_nettype wire

>>> design/msta_chk.sv
// port checker for the mesh segment triangle assembler
`default_nettype none
module msta_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_ax,
  input wire logic [31:0] out_ay,
  input wire logic [31:0] out_az,
  input wire logic [31:0] out_bx,
  input wire logic [31:0] out_by,
  input wire logic [31:0] out_bz,
  input wire logic [31:0] out_cx,
  input wire logic [31:0] out_cy,
  input wire logic [31:0] out_cz,
  input wire logic        out_last_of_run
);
  import msta_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_ax))
    else $error("stalled result beat changed");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TRI |-> out_last_of_run)
    else $error("error beat not last of run");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TRI |-> (out_ax | out_ay | out_az | out_bx | out_by
      | out_bz | out_cx | out_cy | out_cz) == 32'd0)
    else $error("error beat carries coordinates");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_STRIP)
    else $error("status code out of range");

endmodule

bind mesh_segment_triangle_assembler msta_chk u_msta_chk (.*);
`default_nettype wire
